>>> design/bfiq_pkg.sv
// Shared types and constants for the bloom filter insert/query unit.
package bfiq_pkg;

    localparam int          SIZE_W       = 5;
    localparam logic [4:0]  SIZE_RESET   = 5'd16;
    localparam logic [4:0]  SIZE_MIN     = 5'd6;
    localparam int          ROW_W        = 32;
    localparam int          OFS_W        = 5;
    localparam int          HASH_W       = 64;
    localparam logic [63:0] HASH_BASIS   = 64'hcbf29ce484222325;
    localparam logic [63:0] HASH_PRIME_LO = 64'h00000000000001b3;
    localparam int          PRIME_SHIFT  = 40;
    localparam logic        REQ_ADD      = 1'b0;
    localparam logic        REQ_QUERY    = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] key_byte;
        logic       has_byte;
        logic       last_byte;
    } t_req;

    typedef struct packed {
        logic was_query;
        logic maybe_present;
    } t_resp;

    typedef struct packed {
        logic byte_en;
        logic restart;
    } t_hash_ctl;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } t_state;

endpackage

>>> design/bloom_filter_insert_query_unit.sv
// Bloom filter insert/query top level: hashing, probe sequencer and bit store.
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_stall   | i_in_req  (t_req)
//  out     | output    | o_out_valid / i_out_stall | o_out_res (t_resp)
//  cfg     | input     | i_cfg_we                  | i_cfg_data (size_log2)
//
// A request without last_byte leaves the sequencer in ST_IDLE. A request with
// last_byte starts the probes: each is a read then a check/write of one row of
// the bit store via its read and write ports, positions stepped by one adder.
// After reset a clearing pass zeroes the store one row at a time; o_in_stall
// stays high meanwhile. A stalled result holds the sequencer in its last step.
module bloom_filter_insert_query_unit #(
    parameter int MAX_BITS    = 65536,
    parameter int PROBE_COUNT = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bfiq_pkg::t_req                i_in_req,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bfiq_pkg::t_resp               o_out_res,
    input  logic                          i_cfg_we,
    input  logic [bfiq_pkg::SIZE_W-1:0]   i_cfg_data
);

    localparam int ADDR_W = $clog2(MAX_BITS);
    localparam int ROWS   = MAX_BITS / bfiq_pkg::ROW_W;
    localparam int ROW_AW = $clog2(ROWS);
    localparam int PC_W   = (PROBE_COUNT > 1) ? $clog2(PROBE_COUNT) : 1;

    bfiq_pkg::t_state                r_state, n_state;
    logic [bfiq_pkg::SIZE_W-1:0]     r_size;
    logic [ADDR_W-1:0]               r_pos;
    logic [ADDR_W-1:0]               r_step;
    logic [PC_W-1:0]                 r_probe;
    logic [ROW_AW-1:0]               r_row;
    logic [bfiq_pkg::OFS_W-1:0]      r_ofs;
    logic                            r_query;
    logic                            r_all;
    logic [ROW_AW-1:0]               r_clr;
    logic                            r_out_valid;
    bfiq_pkg::t_resp                 r_out_res;

    logic                            accept;
    bfiq_pkg::t_hash_ctl             hash_ctl;
    logic [bfiq_pkg::HASH_W-1:0]     key_hash;
    logic [bfiq_pkg::SIZE_W-1:0]     lg_eff;
    logic [ADDR_W:0]                 mask_full;
    logic [ADDR_W-1:0]               idx;
    logic                            rd_en;
    logic [bfiq_pkg::ROW_W-1:0]      rd_data;
    logic                            wr_en;
    logic [ROW_AW-1:0]               wr_addr;
    logic [bfiq_pkg::ROW_W-1:0]      wr_data;
    logic                            load_out;
    logic                            last_probe;

    assign accept        = i_in_valid && (r_state == bfiq_pkg::ST_IDLE);
    assign hash_ctl.byte_en = accept && i_in_req.has_byte;
    assign hash_ctl.restart = accept && i_in_req.last_byte;

    bfiq_hash u_hash (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (hash_ctl),
        .i_byte     (i_in_req.key_byte),
        .o_key_hash (key_hash)
    );

    bfiq_store #(
        .ROWS (ROWS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (idx[ADDR_W-1:bfiq_pkg::OFS_W]),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    always_comb begin
        if (r_size < bfiq_pkg::SIZE_MIN) begin
            lg_eff = bfiq_pkg::SIZE_MIN;
        end else if (r_size > bfiq_pkg::SIZE_W'(ADDR_W)) begin
            lg_eff = bfiq_pkg::SIZE_W'(ADDR_W);
        end else begin
            lg_eff = r_size;
        end
    end

    assign mask_full  = ((ADDR_W+1)'(1) << lg_eff) - (ADDR_W+1)'(1);
    assign idx        = r_pos & mask_full[ADDR_W-1:0];
    assign last_probe = (r_probe == PC_W'(PROBE_COUNT - 1));

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = r_row;
        wr_data    = rd_data | (bfiq_pkg::ROW_W'(1) << r_ofs);
        load_out   = 1'b0;
        unique case (r_state)
            bfiq_pkg::ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = '0;
                if (r_clr == ROW_AW'(ROWS - 1)) begin
                    n_state = bfiq_pkg::ST_IDLE;
                end
            end
            bfiq_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid && i_in_req.last_byte) begin
                    n_state = bfiq_pkg::ST_READ;
                end
            end
            bfiq_pkg::ST_READ: begin
                rd_en   = 1'b1;
                n_state = bfiq_pkg::ST_CHECK;
            end
            bfiq_pkg::ST_CHECK: begin
                wr_en = (r_query == bfiq_pkg::REQ_ADD);
                if (last_probe) begin
                    n_state = bfiq_pkg::ST_DONE;
                end else begin
                    n_state = bfiq_pkg::ST_READ;
                end
            end
            bfiq_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = bfiq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bfiq_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bfiq_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_size      <= bfiq_pkg::SIZE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == bfiq_pkg::ST_CLEAR) begin
                r_clr <= r_clr + ROW_AW'(1);
            end
            if (i_cfg_we) begin
                r_size <= i_cfg_data;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in_req.last_byte) begin
            r_pos   <= key_hash[ADDR_W-1:0];
            r_step  <= key_hash[ADDR_W-1:0] | ADDR_W'(1);
            r_probe <= '0;
            r_query <= i_in_req.req_type;
            r_all   <= 1'b1;
        end
        if (r_state == bfiq_pkg::ST_READ) begin
            r_row <= idx[ADDR_W-1:bfiq_pkg::OFS_W];
            r_ofs <= idx[bfiq_pkg::OFS_W-1:0];
            r_pos <= r_pos + r_step;
        end
        if (r_state == bfiq_pkg::ST_CHECK) begin
            r_probe <= r_probe + PC_W'(1);
            if ((r_query == bfiq_pkg::REQ_QUERY) && !rd_data[r_ofs]) begin
                r_all <= 1'b0;
            end
        end
        if (load_out) begin
            r_out_res.was_query     <= r_query;
            r_out_res.maybe_present <= r_all;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

endmodule

>>> design/bfiq_hash.sv
// 64-bit FNV-1a accumulator, one key byte per cycle.
module bfiq_hash (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bfiq_pkg::t_hash_ctl             i_ctl,
    input  logic [7:0]                      i_byte,
    output logic [bfiq_pkg::HASH_W-1:0]     o_key_hash
);

    logic [bfiq_pkg::HASH_W-1:0] r_hash;
    logic [bfiq_pkg::HASH_W-1:0] mixed;
    logic [bfiq_pkg::HASH_W-1:0] n_hash;

    // prime = 2^40 + 0x1b3
    assign mixed  = r_hash ^ {{(bfiq_pkg::HASH_W-8){1'b0}}, i_byte};
    assign n_hash = (mixed << bfiq_pkg::PRIME_SHIFT) + (mixed * bfiq_pkg::HASH_PRIME_LO);

    assign o_key_hash = i_ctl.byte_en ? n_hash : r_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= bfiq_pkg::HASH_BASIS;
        end else if (i_ctl.restart) begin
            r_hash <= bfiq_pkg::HASH_BASIS;
        end else if (i_ctl.byte_en) begin
            r_hash <= n_hash;
        end
    end

endmodule

>>> design/bfiq_store.sv
// Filter bit store: rows of bits, one write and one registered read port.
module bfiq_store #(
    parameter int ROWS = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [$clog2(ROWS)-1:0]       i_rd_addr,
    output logic [bfiq_pkg::ROW_W-1:0]    o_rd_data,
    input  logic                          i_wr_en,
    input  logic [$clog2(ROWS)-1:0]       i_wr_addr,
    input  logic [bfiq_pkg::ROW_W-1:0]    i_wr_data
);

    logic [bfiq_pkg::ROW_W-1:0] mem [ROWS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

>>> design/bfiq_checker.sv
// Port-level checks for the bloom filter unit, bound to the top level.
module bfiq_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input bfiq_pkg::t_req  i_in_req,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input bfiq_pkg::t_resp o_out_res
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_res))
        else $error("stalled result changed");

    a_add_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_res.was_query == bfiq_pkg::REQ_ADD) |-> o_out_res.maybe_present)
        else $error("add reported absent");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("not clearing after reset");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_req.last_byte |=> o_in_stall)
        else $error("request accepted during probe sequence");

endmodule

bind bloom_filter_insert_query_unit bfiq_checker u_bfiq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_res   (o_out_res)
);
